### rtl/kbc_pkg.sv
// Shared types and constants for the 8042-style PS/2 keyboard controller.
// No dependencies; compiled first.

package kbc_pkg;

  // Internal RAM: byte 0 is the configuration byte, held in a register.
  localparam int RAM_BYTES = 32;
  localparam int RAM_AW    = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
  localparam int IDX_W     = 5;
  localparam logic [IDX_W:0] RAM_LIMIT = (IDX_W + 1)'(RAM_BYTES);

  // Configuration byte bit positions.
  localparam int CFG_IRQ1     = 0;
  localparam int CFG_IRQ2     = 1;
  localparam int CFG_SYS      = 2;
  localparam int CFG_CLK1_DIS = 4;
  localparam int CFG_CLK2_DIS = 5;

  // Output port bit that drives the A20 gate.
  localparam int OPORT_A20 = 1;

  localparam logic [7:0] OPORT_RESET  = 8'h01;
  localparam logic [7:0] SELF_TEST_OK = 8'h55;
  localparam logic [7:0] PORT_TEST_OK = 8'h00;

  // Controller commands.
  localparam logic [7:0] CMD_DIS_PORT2  = 8'hA7;
  localparam logic [7:0] CMD_EN_PORT2   = 8'hA8;
  localparam logic [7:0] CMD_TEST_PORT2 = 8'hA9;
  localparam logic [7:0] CMD_SELF_TEST  = 8'hAA;
  localparam logic [7:0] CMD_TEST_PORT1 = 8'hAB;
  localparam logic [7:0] CMD_DIS_PORT1  = 8'hAD;
  localparam logic [7:0] CMD_EN_PORT1   = 8'hAE;
  localparam logic [7:0] CMD_WR_OPORT   = 8'hD1;
  localparam logic [7:0] CMD_WR_OUT1    = 8'hD2;
  localparam logic [7:0] CMD_WR_OUT2    = 8'hD3;
  localparam logic [7:0] CMD_WR_DEV2    = 8'hD4;

  typedef enum logic [2:0] {
    ACT_READ_DATA   = 3'd0,
    ACT_READ_STATUS = 3'd1,
    ACT_WRITE_DATA  = 3'd2,
    ACT_WRITE_CMD   = 3'd3,
    ACT_DEV1_BYTE   = 3'd4,
    ACT_DEV2_BYTE   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    PEND_NONE  = 3'd0,
    PEND_RAM   = 3'd1,
    PEND_OPORT = 3'd2,
    PEND_OUT1  = 3'd3,
    PEND_OUT2  = 3'd4,
    PEND_DEV2  = 3'd5
  } pend_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       tx_first_valid;
    logic       tx_second_valid;
    logic [7:0] tx_byte;
    logic       irq_first;
    logic       irq_second;
    logic       reset_pulse;
    logic       a20_gate;
    logic       byte_dropped;
  } rsp_t;

endpackage

### rtl/kbc_if.sv
// Valid/ready channel interfaces for the controller's request and response sides.
// Depends on kbc_pkg for the payload structs.

interface kbc_req_if import kbc_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface kbc_rsp_if import kbc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/kbc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.

module kbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds until the next read.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ps2_keyboard_controller_8042_core.sv
// Top level of the host side of an 8042-style PS/2 keyboard controller.
// Depends on kbc_pkg, the kbc_req_if / kbc_rsp_if interfaces and kbc_ram.
//
//   Channel   Role   Payload                                    Transaction when
//   -------   ----   ----------------------------------------   ---------------------
//   req       sink   action, write_byte                         req.valid & req.ready
//   rsp       source read_byte, tx flags, tx_byte, irqs,        rsp.valid & rsp.ready
//                    reset_pulse, a20_gate, byte_dropped
//   cfg       write  cfg_we, cfg_wdata (second_port_present)    cfg_we
//
// Each request transaction produces exactly one response transaction, from a response
// register. A new request is taken every cycle as long as the response register is
// empty or is being drained in the same cycle, so the sustained rate is one per cycle.
// Reset (rst, synchronous) clears all control state and the RAM valid bits at once;
// there is no clearing pass. A stalled response simply holds req.ready low, and so
// does reset.

module ps2_keyboard_controller_8042_core
  import kbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  kbc_req_if.sink   req,
  kbc_rsp_if.source rsp,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  // Controller registers. The configuration byte (RAM byte 0) is read by status reads,
  // device bytes and many commands, so it is held in a register; bytes 1 and up live in the RAM.
  logic                 second_port_present;
  logic [7:0]           cfg_byte;
  logic [7:0]           out_buffer;
  logic                 out_full;
  logic                 out_from_second;
  logic                 last_was_command;
  pend_t                pend_kind;
  logic [IDX_W-1:0]     pend_index;
  logic [7:0]           output_port;
  logic [RAM_BYTES-1:0] ram_valid;

  // When a RAM read command answers, the buffer's value is the RAM read data that
  // arrives in the next cycle. buf_from_ram selects it; rd_hit says whether the entry
  // read was ever written (an unwritten entry reads as zero).
  logic                 buf_from_ram;
  logic                 rd_hit;

  logic [7:0]           cfg_byte_next;
  logic [7:0]           out_buffer_next;
  logic                 out_full_next;
  logic                 out_from_second_next;
  logic                 last_was_command_next;
  pend_t                pend_kind_next;
  logic [IDX_W-1:0]     pend_index_next;
  logic [7:0]           output_port_next;
  logic                 buf_from_ram_next;
  logic                 rd_hit_next;

  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [RAM_AW-1:0]    ram_raddr;
  logic [7:0]           ram_rdata;

  logic                 fire;
  logic [7:0]           cur_buffer;
  logic [7:0]           b;
  logic [IDX_W-1:0]     cmd_idx;
  rsp_t                 res;

  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign fire      = req.valid && req.ready;
  assign b         = req.payload.write_byte;
  assign cmd_idx   = b[IDX_W-1:0];

  // Forward the RAM read data into the buffer view until something else overwrites it.
  assign cur_buffer = buf_from_ram ? (rd_hit ? ram_rdata : 8'h00) : out_buffer;

  kbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    res                   = '0;
    cfg_byte_next         = cfg_byte;
    out_buffer_next       = out_buffer;
    out_full_next         = out_full;
    out_from_second_next  = out_from_second;
    last_was_command_next = last_was_command;
    pend_kind_next        = pend_kind;
    pend_index_next       = pend_index;
    output_port_next      = output_port;
    buf_from_ram_next     = buf_from_ram;
    rd_hit_next           = rd_hit;
    ram_we                = 1'b0;
    ram_waddr             = pend_index[RAM_AW-1:0];
    ram_wdata             = b;
    ram_re                = 1'b0;
    ram_raddr             = cmd_idx[RAM_AW-1:0];

    unique case (action_t'(req.payload.action))
      ACT_READ_DATA: begin
        res.read_byte = cur_buffer;
        out_full_next = 1'b0;
      end

      ACT_READ_STATUS: begin
        res.read_byte = {2'b00, out_full & out_from_second, 1'b0,
                         last_was_command, cfg_byte[CFG_SYS], 1'b0, out_full};
      end

      ACT_WRITE_DATA: begin
        last_was_command_next = 1'b0;
        pend_kind_next        = PEND_NONE;
        case (pend_kind)
          PEND_RAM: begin
            if (pend_index == '0) begin
              cfg_byte_next = b;
            end else if ({1'b0, pend_index} < RAM_LIMIT) begin
              ram_we = 1'b1;
            end
          end
          PEND_OPORT: begin
            output_port_next = b;
          end
          PEND_OUT1: begin
            out_buffer_next      = b;
            out_full_next        = 1'b1;
            out_from_second_next = 1'b0;
            buf_from_ram_next    = 1'b0;
            res.irq_first        = cfg_byte[CFG_IRQ1];
          end
          PEND_OUT2: begin
            out_buffer_next      = b;
            out_full_next        = 1'b1;
            out_from_second_next = 1'b1;
            buf_from_ram_next    = 1'b0;
            res.irq_second       = cfg_byte[CFG_IRQ2];
          end
          PEND_DEV2: begin
            res.tx_second_valid = 1'b1;
            res.tx_byte         = b;
          end
          default: begin
            // Nothing pending: the byte goes to the first device.
            res.tx_first_valid = 1'b1;
            res.tx_byte        = b;
          end
        endcase
      end

      ACT_WRITE_CMD: begin
        last_was_command_next = 1'b1;
        pend_kind_next        = PEND_NONE;
        unique case (b) inside
          [8'h20:8'h3F]: begin
            // RAM read: the answer overwrites the buffer and counts as first-port.
            out_full_next        = 1'b1;
            out_from_second_next = 1'b0;
            if (cmd_idx == '0) begin
              out_buffer_next   = cfg_byte;
              buf_from_ram_next = 1'b0;
            end else begin
              ram_re            = 1'b1;
              buf_from_ram_next = 1'b1;
              rd_hit_next       = ({1'b0, cmd_idx} < RAM_LIMIT)
                                  && ram_valid[cmd_idx[RAM_AW-1:0]];
            end
          end
          [8'h60:8'h7F]: begin
            pend_kind_next  = PEND_RAM;
            pend_index_next = cmd_idx;
          end
          [8'hF0:8'hFF]: begin
            res.reset_pulse = ~b[0];
          end
          CMD_DIS_PORT2: begin
            if (second_port_present) begin
              cfg_byte_next[CFG_CLK2_DIS] = 1'b1;
            end
          end
          CMD_EN_PORT2: begin
            if (second_port_present) begin
              cfg_byte_next[CFG_CLK2_DIS] = 1'b0;
            end
          end
          CMD_TEST_PORT2: begin
            if (second_port_present) begin
              out_buffer_next      = PORT_TEST_OK;
              out_full_next        = 1'b1;
              out_from_second_next = 1'b0;
              buf_from_ram_next    = 1'b0;
            end
          end
          CMD_SELF_TEST: begin
            out_buffer_next      = SELF_TEST_OK;
            out_full_next        = 1'b1;
            out_from_second_next = 1'b0;
            buf_from_ram_next    = 1'b0;
          end
          CMD_TEST_PORT1: begin
            out_buffer_next      = PORT_TEST_OK;
            out_full_next        = 1'b1;
            out_from_second_next = 1'b0;
            buf_from_ram_next    = 1'b0;
          end
          CMD_DIS_PORT1: begin
            cfg_byte_next[CFG_CLK1_DIS] = 1'b1;
          end
          CMD_EN_PORT1: begin
            cfg_byte_next[CFG_CLK1_DIS] = 1'b0;
          end
          CMD_WR_OPORT: begin
            pend_kind_next = PEND_OPORT;
          end
          CMD_WR_OUT1: begin
            pend_kind_next = PEND_OUT1;
          end
          CMD_WR_OUT2: begin
            if (second_port_present) begin
              pend_kind_next = PEND_OUT2;
            end
          end
          CMD_WR_DEV2: begin
            if (second_port_present) begin
              pend_kind_next = PEND_DEV2;
            end
          end
          default: begin
          end
        endcase
      end

      ACT_DEV1_BYTE: begin
        if (out_full || cfg_byte[CFG_CLK1_DIS]) begin
          res.byte_dropped = 1'b1;
        end else begin
          out_buffer_next      = b;
          out_full_next        = 1'b1;
          out_from_second_next = 1'b0;
          buf_from_ram_next    = 1'b0;
          res.irq_first        = cfg_byte[CFG_IRQ1];
        end
      end

      ACT_DEV2_BYTE: begin
        if (!second_port_present || out_full || cfg_byte[CFG_CLK2_DIS]) begin
          res.byte_dropped = 1'b1;
        end else begin
          out_buffer_next      = b;
          out_full_next        = 1'b1;
          out_from_second_next = 1'b1;
          buf_from_ram_next    = 1'b0;
          res.irq_second       = cfg_byte[CFG_IRQ2];
        end
      end

      default: begin
        // Unused action codes leave the state alone.
      end
    endcase

    res.a20_gate = output_port_next[OPORT_A20];

    // Only a transaction may touch the RAM.
    ram_we = ram_we && fire;
    ram_re = ram_re && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_port_present <= 1'b1;
      cfg_byte            <= '0;
      out_buffer          <= '0;
      out_full            <= 1'b0;
      out_from_second     <= 1'b0;
      last_was_command    <= 1'b0;
      pend_kind           <= PEND_NONE;
      pend_index          <= '0;
      output_port         <= OPORT_RESET;
      ram_valid           <= '0;
      buf_from_ram        <= 1'b0;
      rd_hit              <= 1'b0;
      rsp.valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        second_port_present <= cfg_wdata;
      end
      if (fire) begin
        cfg_byte         <= cfg_byte_next;
        out_buffer       <= out_buffer_next;
        out_full         <= out_full_next;
        out_from_second  <= out_from_second_next;
        last_was_command <= last_was_command_next;
        pend_kind        <= pend_kind_next;
        pend_index       <= pend_index_next;
        output_port      <= output_port_next;
        buf_from_ram     <= buf_from_ram_next;
        rd_hit           <= rd_hit_next;
        rsp.valid        <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (ram_we) begin
        ram_valid[pend_index[RAM_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Response payload register; loaded on every request transaction.
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.payload <= res;
    end
  end

endmodule

### tb/ps2_keyboard_controller_8042_core_checker.sv
// Response checker for the 8042 keyboard controller core, with its own copy of the
// controller state. Depends on kbc_pkg and the kbc_req_if / kbc_rsp_if interfaces.
`timescale 1ns / 100ps

package kbc_tb_pkg;
  import kbc_pkg::*;

  // Command ranges that the package gives no name to.
  localparam logic [7:0] CMD_RD_RAM_FIRST = 8'h20;
  localparam logic [7:0] CMD_RD_RAM_LAST  = 8'h3F;
  localparam logic [7:0] CMD_WR_RAM_FIRST = 8'h60;
  localparam logic [7:0] CMD_WR_RAM_LAST  = 8'h7F;
  localparam logic [7:0] CMD_PULSE_FIRST  = 8'hF0;
  localparam logic [7:0] CMD_PULSE_RESET  = 8'hFE;
  localparam logic [7:0] CMD_PULSE_LAST   = 8'hFF;
endpackage

module ps2_keyboard_controller_8042_core_checker
  import kbc_pkg::*;
  import kbc_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  kbc_req_if   req_mon,
  kbc_rsp_if   rsp_mon,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   fail_count,
  output int   pending_results
);

  // Shadow of the controller state.
  logic [7:0] ram_img [RAM_BYTES];
  logic [7:0] obuf;
  logic       obuf_full;
  logic       obuf_second;
  logic       cmd_last;
  pend_t      wr_target;
  logic [4:0] wr_index;
  logic [7:0] oport_img;
  logic       dual_channel;

  rsp_t expected_rsp_q [$];

  function automatic logic [7:0] ram_peek(input logic [4:0] idx);
    return (int'(idx) < RAM_BYTES) ? ram_img[idx] : 8'h00;
  endfunction

  function automatic void ram_poke(input logic [4:0] idx, input logic [7:0] v);
    if (int'(idx) < RAM_BYTES) ram_img[idx] = v;
  endfunction

  function automatic void load_response(input logic [7:0] v);
    obuf        = v;
    obuf_full   = 1'b1;
    obuf_second = 1'b0;
  endfunction

  // Places a device byte in the buffer; returns that port's interrupt enable.
  function automatic logic load_device(input logic [7:0] v, input logic second);
    logic [7:0] cfg;
    obuf        = v;
    obuf_full   = 1'b1;
    obuf_second = second;
    cfg         = ram_peek(5'd0);
    return second ? cfg[CFG_IRQ2] : cfg[CFG_IRQ1];
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < RAM_BYTES; i++) ram_img[i] = 8'h00;
    obuf         = 8'h00;
    obuf_full    = 1'b0;
    obuf_second  = 1'b0;
    cmd_last     = 1'b0;
    wr_target    = PEND_NONE;
    wr_index     = 5'd0;
    oport_img    = OPORT_RESET;
    dual_channel = 1'b1;
  endfunction

  function automatic rsp_t predict_access(input req_t r);
    rsp_t       o;
    logic [7:0] b;
    logic [7:0] cfg;
    o   = '0;
    b   = r.write_byte;
    cfg = ram_peek(5'd0);
    case (r.action)
      ACT_READ_DATA: begin
        o.read_byte = obuf;
        obuf_full   = 1'b0;
      end
      ACT_READ_STATUS: begin
        o.read_byte[0] = obuf_full;
        o.read_byte[2] = cfg[CFG_SYS];
        o.read_byte[3] = cmd_last;
        o.read_byte[5] = obuf_full & obuf_second;
      end
      ACT_WRITE_DATA: begin
        cmd_last = 1'b0;
        case (wr_target)
          PEND_RAM:   ram_poke(wr_index, b);
          PEND_OPORT: oport_img = b;
          PEND_OUT1:  o.irq_first = load_device(b, 1'b0);
          PEND_OUT2:  o.irq_second = load_device(b, 1'b1);
          PEND_DEV2: begin
            o.tx_second_valid = 1'b1;
            o.tx_byte         = b;
          end
          default: begin
            o.tx_first_valid = 1'b1;
            o.tx_byte        = b;
          end
        endcase
        wr_target = PEND_NONE;
      end
      ACT_WRITE_CMD: begin
        cmd_last  = 1'b1;
        wr_target = PEND_NONE;
        if (b >= CMD_RD_RAM_FIRST && b <= CMD_RD_RAM_LAST) begin
          load_response(ram_peek(b[4:0]));
        end else if (b >= CMD_WR_RAM_FIRST && b <= CMD_WR_RAM_LAST) begin
          wr_target = PEND_RAM;
          wr_index  = b[4:0];
        end else if (b >= CMD_PULSE_FIRST) begin
          o.reset_pulse = ~b[0];
        end else begin
          case (b)
            CMD_DIS_PORT2:  if (dual_channel) ram_poke(5'd0, cfg | (8'h01 << CFG_CLK2_DIS));
            CMD_EN_PORT2:   if (dual_channel) ram_poke(5'd0, cfg & ~(8'h01 << CFG_CLK2_DIS));
            CMD_TEST_PORT2: if (dual_channel) load_response(PORT_TEST_OK);
            CMD_SELF_TEST:  load_response(SELF_TEST_OK);
            CMD_TEST_PORT1: load_response(PORT_TEST_OK);
            CMD_DIS_PORT1:  ram_poke(5'd0, cfg | (8'h01 << CFG_CLK1_DIS));
            CMD_EN_PORT1:   ram_poke(5'd0, cfg & ~(8'h01 << CFG_CLK1_DIS));
            CMD_WR_OPORT:   wr_target = PEND_OPORT;
            CMD_WR_OUT1:    wr_target = PEND_OUT1;
            CMD_WR_OUT2:    if (dual_channel) wr_target = PEND_OUT2;
            CMD_WR_DEV2:    if (dual_channel) wr_target = PEND_DEV2;
            default: ;
          endcase
        end
      end
      ACT_DEV1_BYTE: begin
        if (obuf_full || cfg[CFG_CLK1_DIS]) o.byte_dropped = 1'b1;
        else o.irq_first = load_device(b, 1'b0);
      end
      ACT_DEV2_BYTE: begin
        if (!dual_channel || obuf_full || cfg[CFG_CLK2_DIS]) o.byte_dropped = 1'b1;
        else o.irq_second = load_device(b, 1'b1);
      end
      default: ;
    endcase
    o.a20_gate = oport_img[OPORT_A20];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      reset_shadow();
      expected_rsp_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) dual_channel = cfg_wdata;
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding: 0x%0h", got);
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("tx_first_valid", want.tx_first_valid, got.tx_first_valid);
          check_field("tx_second_valid", want.tx_second_valid, got.tx_second_valid);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("irq_first", want.irq_first, got.irq_first);
          check_field("irq_second", want.irq_second, got.irq_second);
          check_field("reset_pulse", want.reset_pulse, got.reset_pulse);
          check_field("a20_gate", want.a20_gate, got.a20_gate);
          check_field("byte_dropped", want.byte_dropped, got.byte_dropped);
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_rsp_q.push_back(predict_access(req_mon.payload));
    end
    pending_results <= expected_rsp_q.size();
  end

endmodule

### tb/ps2_keyboard_controller_8042_core_tb.sv
// Top of the testbench for the 8042 keyboard controller core: clock, reset, stimulus
// and verdict. Depends on kbc_pkg, the channel interfaces, kbc_tb_pkg and the checker.
`timescale 1ns / 100ps

module ps2_keyboard_controller_8042_core_tb;
  import kbc_pkg::*;
  import kbc_tb_pkg::*;

  // Items per random phase; four phases alternate the second-port setting.
  localparam int PHASE_ITEMS  = 345;
  // The receiver's long hold-off, long enough to fill the one-deep response stage.
  localparam int HOLD_CYCLES  = 80;
  // Cycles without any transaction before the run is declared hung.
  localparam int IDLE_LIMIT   = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_wdata;
  logic hold_request = 1'b0;

  int fail_count;
  int pending_results;
  int items_sent = 0;
  int burst_left = 8;
  int idle_cycles = 0;

  kbc_req_if req_ch ();
  kbc_rsp_if rsp_ch ();

  ps2_keyboard_controller_8042_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ps2_keyboard_controller_8042_core_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .req_mon         (req_ch),
    .rsp_mon         (rsp_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Offers one request and waits for its transaction. The sender works in bursts:
  // when a burst runs out, valid may drop for a random gap before the next one starts.
  // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_access(input action_t act, input logic [7:0] data);
    int gap;
    req_ch.valid   <= 1'b1;
    req_ch.payload <= {act, data};
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering requests and waits until every predicted response has been taken,
  // then waits out the registered response stage.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (2) @(posedge clk);
  endtask

  // The register is only written while the controller has nothing in flight.
  task automatic write_config(input logic second_present);
    cfg_we    <= 1'b1;
    cfg_wdata <= second_present;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Picks a command byte, weighted toward the commands the controller acts on, with a
  // share of fully random bytes so that the unlisted commands are reached as well.
  function automatic logic [7:0] pick_command();
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0, 1: c = CMD_RD_RAM_FIRST | 8'($urandom_range(0, 31));
      2:    c = CMD_WR_RAM_FIRST | 8'($urandom_range(0, 31));
      3:    c = CMD_WR_RAM_FIRST;
      4:    c = CMD_RD_RAM_FIRST;
      5:    c = $urandom_range(0, 2) == 0 ? CMD_DIS_PORT2 : CMD_EN_PORT2;
      6:    c = $urandom_range(0, 2) == 0 ? CMD_DIS_PORT1 : CMD_EN_PORT1;
      7: begin
        case ($urandom_range(0, 2))
          0:       c = CMD_TEST_PORT2;
          1:       c = CMD_SELF_TEST;
          default: c = CMD_TEST_PORT1;
        endcase
      end
      8:       c = CMD_WR_OPORT;
      9:       c = CMD_WR_OUT1;
      10:      c = CMD_WR_OUT2;
      11:      c = CMD_WR_DEV2;
      12:      c = CMD_PULSE_FIRST | 8'($urandom_range(0, 15));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // One random exchange. Most of them are well-formed: a redirecting command is
  // usually followed by its data byte, and a controller answer or a device byte is
  // usually read back, which keeps the output buffer from staying full. The rest are
  // loose reads, stray data writes and commands that cancel a pending write.
  task automatic random_sequence();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c = pick_command();
      send_access(ACT_WRITE_CMD, c);
      if ((c >= CMD_WR_RAM_FIRST && c <= CMD_WR_RAM_LAST) || c == CMD_WR_OPORT ||
          c == CMD_WR_OUT1 || c == CMD_WR_OUT2 || c == CMD_WR_DEV2) begin
        if ($urandom_range(0, 9) == 0) send_access(ACT_WRITE_CMD, pick_command());
        else send_access(ACT_WRITE_DATA, 8'($urandom_range(0, 255)));
      end else if ((c >= CMD_RD_RAM_FIRST && c <= CMD_RD_RAM_LAST) ||
                   c == CMD_TEST_PORT2 || c == CMD_SELF_TEST || c == CMD_TEST_PORT1) begin
        if ($urandom_range(0, 1)) send_access(ACT_READ_STATUS, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) != 0) send_access(ACT_READ_DATA, 8'($urandom_range(0, 255)));
      end
    end else if (pick < 65) begin
      send_access($urandom_range(0, 1) ? ACT_DEV1_BYTE : ACT_DEV2_BYTE,
                  8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) send_access(ACT_READ_STATUS, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) send_access(ACT_READ_DATA, 8'($urandom_range(0, 255)));
    end else if (pick < 78) begin
      send_access(ACT_READ_DATA, 8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      send_access(ACT_READ_STATUS, 8'($urandom_range(0, 255)));
    end else begin
      send_access(ACT_WRITE_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver side. It runs through stretches of random length, each with its own
  // acceptance pattern: always ready, coin flip, mostly stalled or mostly ready. When
  // the stimulus asks for it, ready is held low for a long stretch while the sender
  // keeps offering, so the response stage fills and the request side backs up.
  initial begin : response_sink
    int mode;
    int span;
    bit hold_taken;
    hold_taken = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 60);
      for (int k = 0; k < span; k++) begin
        if (hold_request && !hold_taken) begin
          hold_taken = 1'b1;
          rsp_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: a run in which no transaction of any kind happens for too long is hung.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int  target;
    bit  hold_done;
    bit  pause_done;
    hold_done       = 1'b0;
    pause_done      = 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    rst            <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_config(1'b1);

    // Directed part. It starts from the reset state, so the first data read returns
    // the stale empty buffer, and the configuration byte is then set to enable both
    // interrupts and the system flag.
    send_access(ACT_READ_STATUS, 8'h00);
    send_access(ACT_READ_DATA, 8'hFF);
    send_access(ACT_WRITE_CMD, CMD_WR_RAM_FIRST);
    send_access(ACT_WRITE_DATA, 8'h07);
    send_access(ACT_WRITE_CMD, CMD_RD_RAM_FIRST);
    // The self-test answer overwrites the still-full buffer.
    send_access(ACT_WRITE_CMD, CMD_SELF_TEST);
    send_access(ACT_READ_STATUS, 8'h00);
    send_access(ACT_READ_DATA, 8'h00);
    // First device: buffered with an interrupt, then dropped while the buffer is full,
    // then dropped while its clock is disabled.
    send_access(ACT_DEV1_BYTE, 8'hFF);
    send_access(ACT_DEV1_BYTE, 8'h00);
    send_access(ACT_READ_DATA, 8'h00);
    send_access(ACT_WRITE_CMD, CMD_DIS_PORT1);
    send_access(ACT_DEV1_BYTE, 8'h12);
    send_access(ACT_WRITE_CMD, CMD_EN_PORT1);
    // Second device, disabled and then enabled; the status shows the second-port flag.
    send_access(ACT_WRITE_CMD, CMD_DIS_PORT2);
    send_access(ACT_DEV2_BYTE, 8'h34);
    send_access(ACT_WRITE_CMD, CMD_EN_PORT2);
    send_access(ACT_DEV2_BYTE, 8'hFF);
    send_access(ACT_READ_STATUS, 8'hFF);
    // Transmit to the second device, then a data write with nothing pending.
    send_access(ACT_WRITE_CMD, CMD_WR_DEV2);
    send_access(ACT_WRITE_DATA, 8'hA5);
    send_access(ACT_WRITE_DATA, 8'hFF);
    // Output port load raises A20 without a reset pulse; then the reset commands.
    send_access(ACT_WRITE_CMD, CMD_WR_OPORT);
    send_access(ACT_WRITE_DATA, 8'hFE);
    send_access(ACT_WRITE_CMD, CMD_PULSE_RESET);
    send_access(ACT_WRITE_CMD, CMD_PULSE_LAST);
    // A pending RAM write cancelled by a new command; the data goes to the first device.
    send_access(ACT_WRITE_CMD, CMD_WR_RAM_LAST);
    send_access(ACT_WRITE_CMD, CMD_TEST_PORT1);
    send_access(ACT_WRITE_DATA, 8'h00);
    drain_results();

    // Random phases, alternating a dual-channel and a single-channel controller.
    for (int phase = 0; phase < 4; phase++) begin
      write_config(phase % 2 == 0);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (phase == 0 && !hold_done && items_sent >= target - PHASE_ITEMS / 2) begin
          hold_request <= 1'b1;
          hold_done = 1'b1;
        end
        if (phase == 1 && !pause_done && items_sent >= target - PHASE_ITEMS / 2) begin
          drain_results();
          pause_done = 1'b1;
        end
        random_sequence();
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
